### rtl/core/bhpq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bhpq_pkg
// shared types and constants for the binary heap priority queue
// ----------------------------------------------------------------------------
package bhpq_pkg;

    localparam int CAPACITY = 1024;
    localparam int AW       = $clog2(CAPACITY);
    localparam int CW       = AW + 1;

    localparam logic [1:0] REQ_ADD = 2'd0;
    localparam logic [1:0] REQ_DEL = 2'd1;
    localparam logic [1:0] REQ_UPD = 2'd2;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_INVALID = 2'd1;
    localparam logic [1:0] ST_FULL    = 2'd2;

    typedef logic [AW-1:0] addr_t;
    typedef logic [CW-1:0] count_t;

    // true when a must sit above b
    function automatic logic beats(input logic [31:0] a, input logic [31:0] b,
                                   input logic is_min);
        logic lt;
        logic gt;
        lt = $signed(a) < $signed(b);
        gt = $signed(a) > $signed(b);
        return is_min ? lt : gt;
    endfunction

endpackage

### rtl/core/binary_heap_priority_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// array-backed min/max binary heap with add, delete and update at index
// ----------------------------------------------------------------------------
// throughput: one request at a time, the next accepted the cycle after the result beat
// reset: synchronous active-low clears count, mode and handshake; memory
// contents are left as they are (never read before written)
// ----------------------------------------------------------------------------
module binary_heap_priority_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        heap_is_min_we,
    input  logic        heap_is_min_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // req_type[1:0], index[11:2], value[43:12], pad
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata    // status[1:0], removed[33:2], top[65:34], count[76:66]
);

    // sequencer codes
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_RDL   = 4'd1;  // read last entry (delete)
    localparam logic [3:0] S_WRH   = 4'd2;  // write hole / start settle
    localparam logic [3:0] S_UPR   = 4'd3;  // read parent
    localparam logic [3:0] S_UPC   = 4'd4;  // compare with parent
    localparam logic [3:0] S_DNR1  = 4'd5;  // read left child
    localparam logic [3:0] S_DNR2  = 4'd6;  // read right child
    localparam logic [3:0] S_DNC   = 4'd7;  // compare children
    localparam logic [3:0] S_ROOT  = 4'd8;  // issue root read
    localparam logic [3:0] S_ROOTW = 4'd9;  // capture root
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_FIRC  = 4'd12;
    localparam logic [3:0] S_DELR  = 4'd13; // read removed entry
    localparam logic [3:0] S_DNW   = 4'd14; // write sifted entry at new spot

    logic [31:0] mem [bhpq_pkg::CAPACITY];
    logic        mem_we;
    bhpq_pkg::addr_t mem_wa, mem_ra;
    logic [31:0] mem_wd, mem_rd;

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        mem_rd <= mem[mem_ra];
    end

    logic [3:0]  state_reg, state_next;
    logic        min_reg;
    bhpq_pkg::count_t cnt_reg, cnt_next;
    bhpq_pkg::addr_t  pos_reg, pos_next;
    logic [31:0] val_reg, val_next;      // entry being sifted
    logic [31:0] lv_reg, lv_next;        // left child value
    logic [1:0]  st_reg, st_next;
    logic [31:0] rem_reg, rem_next;
    logic [31:0] top_reg, top_next;
    logic        mv_reg, mv_next;

    logic [1:0]  in_req;
    bhpq_pkg::addr_t in_idx;
    logic [31:0] in_val;
    assign in_req = s_tdata[1:0];
    assign in_idx = s_tdata[11:2];
    assign in_val = s_tdata[43:12];

    // tree neighbors, widened to catch out-of-range children
    logic [bhpq_pkg::CW:0] lch, rch;
    bhpq_pkg::addr_t par;
    assign lch = {1'b0, pos_reg, 1'b1};
    assign rch = {1'b0, pos_reg, 1'b0} + (bhpq_pkg::CW+1)'(2);
    assign par = (pos_reg - bhpq_pkg::AW'(1)) >> 1;

    logic l_ok, r_ok;
    assign l_ok = lch < {1'b0, cnt_reg};
    assign r_ok = rch < {1'b0, cnt_reg};

    assign s_tready = (state_reg == S_IDLE) && !mv_reg;
    assign m_tvalid = mv_reg;
    assign m_tdata  = {3'd0, cnt_reg, top_reg, rem_reg, st_reg};

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        val_next   = val_reg;
        lv_next    = lv_reg;
        st_next    = st_reg;
        rem_next   = rem_reg;
        top_next   = top_reg;
        mv_next    = mv_reg;
        mem_we     = 1'b0;
        mem_wa     = pos_reg;
        mem_wd     = val_reg;
        mem_ra     = pos_reg;
        if (mv_reg && m_tready) begin
            mv_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    st_next  = bhpq_pkg::ST_OK;
                    rem_next = '0;
                    val_next = in_val;
                    pos_next = in_idx;
                    case (in_req)
                        bhpq_pkg::REQ_ADD: begin
                            if (cnt_reg >= bhpq_pkg::count_t'(bhpq_pkg::CAPACITY)) begin
                                st_next    = bhpq_pkg::ST_FULL;
                                state_next = S_ROOT;
                            end else begin
                                pos_next   = cnt_reg[bhpq_pkg::AW-1:0];
                                cnt_next   = cnt_reg + bhpq_pkg::count_t'(1);
                                state_next = S_UPR;
                            end
                        end
                        bhpq_pkg::REQ_DEL: begin
                            if ({1'b0, in_idx} >= cnt_reg) begin
                                st_next    = bhpq_pkg::ST_INVALID;
                                state_next = S_ROOT;
                            end else begin
                                mem_ra     = in_idx;
                                cnt_next   = cnt_reg - bhpq_pkg::count_t'(1);
                                state_next = S_DELR;
                            end
                        end
                        bhpq_pkg::REQ_UPD: begin
                            if ({1'b0, in_idx} >= cnt_reg) begin
                                st_next    = bhpq_pkg::ST_INVALID;
                                state_next = S_ROOT;
                            end else begin
                                state_next = S_WRH;
                            end
                        end
                        default: begin
                            st_next    = bhpq_pkg::ST_INVALID;
                            state_next = S_ROOT;
                        end
                    endcase
                end
            end
            S_DELR: begin
                rem_next = mem_rd;
                if ({1'b0, pos_reg} == cnt_reg) begin
                    state_next = S_ROOT;
                end else begin
                    mem_ra     = cnt_reg[bhpq_pkg::AW-1:0];
                    state_next = S_RDL;
                end
            end
            S_RDL: begin
                val_next   = mem_rd;
                state_next = S_WRH;
            end
            S_WRH: begin
                mem_we = 1'b1;
                if (pos_reg == '0) begin
                    state_next = S_DNR1;
                end else begin
                    mem_ra     = par;
                    state_next = S_FIRC;
                end
            end
            S_FIRC: begin
                if (bhpq_pkg::beats(val_reg, mem_rd, min_reg)) begin
                    // read the parent again for the sift-up compare
                    mem_ra     = par;
                    state_next = S_UPC;
                end else begin
                    state_next = S_DNR1;
                end
            end
            S_UPR: begin
                // add or sift-up step: place value then look at parent
                mem_we = 1'b1;
                if (pos_reg == '0) begin
                    state_next = S_ROOT;
                end else begin
                    mem_ra     = par;
                    state_next = S_UPC;
                end
            end
            S_UPC: begin
                if (bhpq_pkg::beats(val_reg, mem_rd, min_reg)) begin
                    mem_we     = 1'b1;
                    mem_wa     = pos_reg;
                    mem_wd     = mem_rd;
                    pos_next   = par;
                    state_next = S_UPR;
                end else begin
                    state_next = S_ROOT;
                end
            end
            S_DNR1: begin
                if (!l_ok) begin
                    state_next = S_ROOT;
                end else begin
                    mem_ra     = lch[bhpq_pkg::AW-1:0];
                    state_next = S_DNR2;
                end
            end
            S_DNR2: begin
                lv_next    = mem_rd;
                mem_ra     = rch[bhpq_pkg::AW-1:0];
                state_next = S_DNC;
            end
            S_DNC: begin
                state_next = S_ROOT;
                if (r_ok && bhpq_pkg::beats(mem_rd, val_reg, min_reg) &&
                    !bhpq_pkg::beats(lv_reg, mem_rd, min_reg) &&
                    (bhpq_pkg::beats(mem_rd, lv_reg, min_reg) ||
                     !bhpq_pkg::beats(lv_reg, val_reg, min_reg))) begin
                    mem_we     = 1'b1;
                    mem_wd     = mem_rd;
                    pos_next   = rch[bhpq_pkg::AW-1:0];
                    state_next = S_WRH;
                end else if (bhpq_pkg::beats(lv_reg, val_reg, min_reg)) begin
                    mem_we     = 1'b1;
                    mem_wd     = lv_reg;
                    pos_next   = lch[bhpq_pkg::AW-1:0];
                    state_next = S_WRH;
                end
                if (state_next == S_WRH) begin
                    // continue down; parent check unnecessary
                    state_next = S_DNW;
                end
            end
            S_DNW: begin
                mem_we     = 1'b1;
                state_next = S_DNR1;
            end
            S_ROOT: begin
                mem_ra     = '0;
                state_next = S_ROOTW;
            end
            S_ROOTW: begin
                top_next   = (cnt_reg != '0) ? mem_rd : '0;
                state_next = S_OUT;
            end
            S_OUT: begin
                if (!mv_reg) begin
                    mv_next    = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            min_reg   <= 1'b0;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            mv_reg    <= mv_next;
            if (heap_is_min_we) begin
                min_reg <= heap_is_min_wdata;
            end
        end
        pos_reg <= pos_next;
        val_reg <= val_next;
        lv_reg  <= lv_next;
        st_reg  <= st_next;
        rem_reg <= rem_next;
        top_reg <= top_next;
    end

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// heap queue testbench
// drives add, delete and update requests into the heap queue over the stream
// ports, predicts every result from a private copy of the heap and compares
// each result beat with the oldest prediction, under random idling on both
// sides and in both heap orders
// ----------------------------------------------------------------------------
module testbench;

    localparam logic [1:0] REQ_NONE = 2'd3;   // unused request code
    localparam int IDLE_LIMIT = 3000;
    localparam int DEEP_COUNT = 160;          // heap size for the no-idle phase

    typedef struct {
        logic [1:0]  status;
        logic [31:0] removed;
        logic [31:0] top;
        bhpq_pkg::count_t count;
    } heap_result_t;

    // private heap and the results it predicts
    class heap_scoreboard;
        logic [31:0]  store [bhpq_pkg::CAPACITY];
        int           count;
        bit           is_min;
        heap_result_t pending_q [$];
        int           errors;

        function bit above(int a, int b);
            if (is_min) return $signed(store[a]) < $signed(store[b]);
            return $signed(store[a]) > $signed(store[b]);
        endfunction

        function void swap_pos(int a, int b);
            logic [31:0] t;
            t = store[a];
            store[a] = store[b];
            store[b] = t;
        endfunction

        function void rise(int pos);
            while (pos != 0 && above(pos, (pos - 1) / 2)) begin
                swap_pos(pos, (pos - 1) / 2);
                pos = (pos - 1) / 2;
            end
        endfunction

        function void sink(int pos);
            int best;
            forever begin
                best = pos;
                if (2*pos+1 < count && above(2*pos+1, best)) best = 2*pos+1;
                if (2*pos+2 < count && above(2*pos+2, best)) best = 2*pos+2;
                if (best == pos) break;
                swap_pos(best, pos);
                pos = best;
            end
        endfunction

        function void reheap(int pos);
            if (pos != 0 && above(pos, (pos - 1) / 2)) rise(pos);
            else sink(pos);
        endfunction

        // work out the result of one accepted request
        function void note_request(logic [1:0] req, logic [9:0] idx, logic [31:0] val);
            heap_result_t r;
            r.status  = bhpq_pkg::ST_OK;
            r.removed = '0;
            case (req)
                bhpq_pkg::REQ_ADD: begin
                    if (count >= bhpq_pkg::CAPACITY) r.status = bhpq_pkg::ST_FULL;
                    else begin
                        store[count] = val;
                        count++;
                        rise(count - 1);
                    end
                end
                bhpq_pkg::REQ_DEL: begin
                    if (idx >= count) r.status = bhpq_pkg::ST_INVALID;
                    else begin
                        r.removed = store[idx];
                        count--;
                        if (idx != count) begin
                            store[idx] = store[count];
                            reheap(idx);
                        end
                    end
                end
                bhpq_pkg::REQ_UPD: begin
                    if (idx >= count) r.status = bhpq_pkg::ST_INVALID;
                    else begin
                        store[idx] = val;
                        reheap(idx);
                    end
                end
                default: r.status = bhpq_pkg::ST_INVALID;
            endcase
            r.top   = count != 0 ? store[0] : '0;
            r.count = bhpq_pkg::count_t'(count);
            pending_q.push_back(r);
        endfunction

        function void check_result(logic [79:0] d);
            heap_result_t e;
            if (pending_q.size() == 0) begin
                $display("%0t: result beat with nothing expected, data %h", $time, d);
                errors++;
                return;
            end
            e = pending_q.pop_front();
            if (d[1:0] !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, d[1:0]);
                errors++;
            end
            if (d[33:2] !== e.removed) begin
                $display("%0t: removed expected %h actual %h", $time, e.removed, d[33:2]);
                errors++;
            end
            if (d[65:34] !== e.top) begin
                $display("%0t: top expected %h actual %h", $time, e.top, d[65:34]);
                errors++;
            end
            if (d[76:66] !== e.count) begin
                $display("%0t: count expected %0d actual %0d", $time, e.count, d[76:66]);
                errors++;
            end
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        heap_is_min_we = 1'b0;
    logic        heap_is_min_wdata = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // req_type[1:0], index[11:2], value[43:12], pad
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [79:0] m_tdata;        // status[1:0], removed[33:2], top[65:34], count[76:66]

    heap_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int hold_cycles = 0;     // receiver hold-off request, counted down below
    int quiet_cycles = 0;

    binary_heap_priority_queue u_dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .heap_is_min_we    (heap_is_min_we),
        .heap_is_min_wdata (heap_is_min_wdata),
        .s_tvalid          (s_tvalid),
        .s_tready          (s_tready),
        .s_tdata           (s_tdata),
        .m_tvalid          (m_tvalid),
        .m_tready          (m_tready),
        .m_tdata           (m_tdata)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // result side: check every beat, stall at random or for a long hold-off
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata);
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= aresetn && ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one request beat, with a random gap before it; called right after an edge
    task automatic send_request(logic [1:0] req, logic [9:0] idx, logic [31:0] val);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, val, idx, req};
        do @(posedge aclk); while (!s_tready);
        sb.note_request(req, idx, val);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (sb.pending_q.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // only while idle
    task automatic write_order(bit min_first);
        heap_is_min_we    <= 1'b1;
        heap_is_min_wdata <= min_first;
        @(posedge aclk);
        heap_is_min_we <= 1'b0;
        sb.is_min = min_first;
    endtask

    // many ties and extremes mixed into full-range values
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0: return 32'(int'($urandom_range(0, 8)) - 4);
            1: return $urandom_range(0, 1) ? 32'h7fff_ffff : 32'h8000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic random_request(int add_pct);
        int roll;
        logic [9:0] idx;
        roll = $urandom_range(0, 99);
        idx  = sb.count > 0 ? 10'($urandom_range(0, sb.count - 1)) : 10'd0;
        if ($urandom_range(0, 19) == 0) begin
            // noise: unknown code or an index anywhere
            idx = 10'($urandom_range(0, 1023));
            send_request($urandom_range(0, 1) ? REQ_NONE : 2'($urandom_range(1, 2)),
                         idx, $urandom);
        end else if (roll < add_pct) begin
            send_request(bhpq_pkg::REQ_ADD, 10'($urandom_range(0, 1023)), pick_value());
        end else if (roll < add_pct + (100 - add_pct) / 2) begin
            send_request(bhpq_pkg::REQ_DEL, idx, $urandom);
        end else begin
            send_request(bhpq_pkg::REQ_UPD, idx, pick_value());
        end
    endtask

    initial begin
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: max order, empty heap cases first
        write_order(1'b0);
        send_request(bhpq_pkg::REQ_DEL, 10'd0, 32'h0);
        send_request(bhpq_pkg::REQ_UPD, 10'd0, 32'h1);
        send_request(REQ_NONE, 10'h3ff, 32'hffff_ffff);
        send_request(bhpq_pkg::REQ_ADD, 10'h3ff, 32'h8000_0000);
        send_request(bhpq_pkg::REQ_ADD, 10'd0, 32'h7fff_ffff);
        send_request(bhpq_pkg::REQ_ADD, 10'd0, 32'h0);
        send_request(bhpq_pkg::REQ_ADD, 10'd0, 32'hffff_ffff);
        send_request(bhpq_pkg::REQ_ADD, 10'd0, 32'h0);          // tie with an existing entry
        send_request(bhpq_pkg::REQ_ADD, 10'd0, 32'h7fff_ffff);  // tie at the root
        send_request(bhpq_pkg::REQ_DEL, 10'd5, 32'h0);          // last entry, no sift
        send_request(bhpq_pkg::REQ_DEL, 10'd0, 32'h0);          // root
        send_request(bhpq_pkg::REQ_UPD, 10'd0, 32'h8000_0000);  // root sinks
        send_request(bhpq_pkg::REQ_UPD, 10'd3, 32'h7fff_ffff);  // leaf rises
        send_request(bhpq_pkg::REQ_DEL, 10'd4, 32'h0);          // at count, invalid
        send_request(bhpq_pkg::REQ_UPD, 10'h3ff, 32'h5);
        send_request(bhpq_pkg::REQ_DEL, 10'd1, 32'h0);

        // sender idles often less than receiver
        tx_idle_pct = 13;
        rx_idle_pct = 68;
        repeat (200) random_request(50);
        drain();

        // min order, roles swapped, with a long receiver hold-off
        write_order(1'b1);
        tx_idle_pct = 68;
        rx_idle_pct = 13;
        repeat (120) random_request(50);
        tx_idle_pct = 0;
        hold_cycles = 300;
        repeat (30) random_request(50);
        tx_idle_pct = 68;
        repeat (120) random_request(50);
        drain();

        // max order, no idling: grow a deeper heap, then work at depth
        write_order(1'b0);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        while (sb.count < DEEP_COUNT) send_request(bhpq_pkg::REQ_ADD, 10'd0, pick_value());
        send_request(bhpq_pkg::REQ_ADD, 10'd0, 32'h7fff_ffff);
        send_request(bhpq_pkg::REQ_UPD, 10'h3ff, 32'h7fff_ffff);
        send_request(bhpq_pkg::REQ_DEL, 10'h3ff, 32'h0);
        send_request(bhpq_pkg::REQ_ADD, 10'd0, 32'h8000_0000);
        repeat (80) random_request(34);
        drain();

        // min order on the leftover heap, then empty it
        write_order(1'b1);
        repeat (60) random_request(40);
        while (sb.count > 0) begin
            send_request(bhpq_pkg::REQ_DEL, 10'($urandom_range(0, sb.count - 1)), 32'h0);
        end
        send_request(bhpq_pkg::REQ_DEL, 10'd0, 32'h0);
        drain();

        if (sb.errors == 0 && sb.pending_q.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
